### rtl/core/first_fit_heap_allocator_defines.svh
// Assertion macros for the first-fit heap allocator.
// Depends on nothing; included by the modules that carry assertions.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef ASSERT_OFF
`define FFHA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FFHA_ASSERT(label, clk, rst_n, prop, msg)
`define FFHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Depends on nothing.
package ffha_pkg;
  localparam int unsigned HeapBytesDefault = 65536;
  localparam int unsigned MetaBytesDefault = 24;
  localparam int unsigned SplitSlack       = 32;

  typedef enum logic [1:0] {
    ActAlloc   = 2'd0,
    ActRelease = 2'd1,
    ActReport  = 2'd2,
    ActSpare   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StNoFit   = 2'd1,
    StBadAddr = 2'd2,
    StSpare   = 2'd3
  } status_e;
endpackage

### rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator: top level with list-walking sequencer.
// Depends on ffha_pkg, ffha_header_ram and first_fit_heap_allocator_defines.svh.
//
// Channel  Direction  Handshake                 Payload
// request  in         start & !busy             action_i, request_size_i, release_address_i
// result   out        done_o (one cycle)        status_o, payload_address_o, free_bytes_o
//
// A report goes straight from the request to the result state. Allocate and release
// scan the header list one block at a time; a split moves the list tail up entry by
// entry, a release re-walks the whole list to merge, and each allocate or release that
// succeeds then recounts the free total over every block.
// Reset clears only control state; the header memory is undefined until written.
// busy drops in the result cycle; the result strobe lasts one cycle and cannot be stalled.
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator #(
  parameter int unsigned HEAP_BYTES = ffha_pkg::HeapBytesDefault,
  parameter int unsigned META_BYTES = ffha_pkg::MetaBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] release_address_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [15:0] payload_address_o,
  output logic [16:0] free_bytes_o
);
  localparam int unsigned Depth = HEAP_BYTES / 8;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = AW + 1;
  localparam int unsigned SW    = $clog2(HEAP_BYTES) + 1;
  localparam logic [SW-1:0] Meta   = SW'(META_BYTES);
  localparam logic [SW-1:0] Slack  = SW'(ffha_pkg::SplitSlack);
  localparam logic [SW-1:0] InitSz = SW'(HEAP_BYTES - META_BYTES);
  localparam logic [CW-1:0] MaxCnt = CW'(Depth);

  typedef enum logic [9:0] {
    SIdle   = 10'b0000000001,
    SRead   = 10'b0000000010,
    SScan   = 10'b0000000100,
    SShRd   = 10'b0000001000,
    SShWr   = 10'b0000010000,
    SMgRd   = 10'b0000100000,
    SMgChk  = 10'b0001000000,
    SCntRd  = 10'b0010000000,
    SCntAcc = 10'b0100000000,
    SDone   = 10'b1000000000
  } state_e;

  state_e          state_q, state_d;
  logic            ready_q, ready_d;
  logic [16:0]     free_q, free_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic [SW-1:0]   off_q, off_d;
  logic [SW-1:0]   sum_q, sum_d;
  logic [SW-1:0]   need_q, need_d;
  logic [15:0]     addr_q, addr_d;
  logic            isalloc_q, isalloc_d;
  logic [1:0]      st_q, st_d;
  logic [15:0]     pay_q, pay_d;
  logic [SW:0]     prev_q, prev_d;  // previous entry in merge walk, or split remainder
  logic            done_q, done_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [31:0]     wdata, rdata;
  logic [SW-1:0]   esz;
  logic            efree;
  logic [SW-1:0]   mg_sz;

  ffha_header_ram #(.Depth(Depth), .Width(32)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign esz   = rdata[SW:1];
  assign efree = rdata[0];
  assign mg_sz = prev_q[SW:1] + Meta + esz;

  always_comb begin
    state_d = state_q; ready_d = ready_q; free_d = free_q; cnt_d = cnt_q;
    idx_d = idx_q; ptr_d = ptr_q; off_d = off_q; sum_d = sum_q; need_d = need_q;
    addr_d = addr_q; isalloc_d = isalloc_q; st_d = st_q; pay_d = pay_q;
    prev_d = prev_q; done_d = 1'b0;
    we = 1'b0; waddr = idx_q[AW-1:0]; wdata = '0; raddr = idx_q[AW-1:0];
    unique case (state_q)
      SIdle: begin
        if (start) begin
          idx_d = '0; off_d = '0; st_d = ffha_pkg::StOk; pay_d = '0;
          addr_d = release_address_i;
          need_d = (SW'(request_size_i) + SW'(7)) & ~SW'(7);
          isalloc_d = (action_i == ffha_pkg::ActAlloc);
          if (action_i == ffha_pkg::ActAlloc) begin
            if (!ready_q) begin
              // create the single initial free block
              we = 1'b1; waddr = '0; wdata = 32'({InitSz, 1'b1});
              cnt_d = CW'(1); ready_d = 1'b1; free_d = 17'(InitSz);
            end
            state_d = SRead;
          end else if (action_i == ffha_pkg::ActRelease) begin
            state_d = SRead;
          end else begin
            state_d = SDone;
          end
        end
      end
      SRead: begin
        if (idx_q >= cnt_q) begin
          st_d = isalloc_q ? ffha_pkg::StNoFit : ffha_pkg::StBadAddr;
          state_d = SDone;
        end else begin
          state_d = SScan;
        end
      end
      SScan: begin
        if (isalloc_q) begin
          if (efree && esz >= need_q) begin
            pay_d = 16'(off_q + Meta);
            if (esz > need_q + Meta + Slack && cnt_q < MaxCnt) begin
              we = 1'b1; wdata = 32'({need_q, 1'b0});
              // remainder goes in at idx+1 once the tail has moved up
              prev_d = {esz - need_q - Meta, 1'b1};
              ptr_d = cnt_q; cnt_d = cnt_q + CW'(1);
              state_d = SShRd;
            end else begin
              we = 1'b1; wdata = 32'({esz, 1'b0});
              state_d = SCntRd;
            end
          end else begin
            off_d = off_q + Meta + esz;
            idx_d = idx_q + CW'(1);
            state_d = SRead;
          end
        end else begin
          if (off_q + Meta == SW'(addr_q)) begin
            we = 1'b1; wdata = 32'({esz, 1'b1});
            idx_d = '0; ptr_d = '0;
            state_d = SMgRd;
          end else begin
            off_d = off_q + Meta + esz;
            idx_d = idx_q + CW'(1);
            state_d = SRead;
          end
        end
      end
      // move entries ptr-1 -> ptr downwards until ptr == idx+1
      SShRd: begin
        if (ptr_q == idx_q + CW'(1)) begin
          we = 1'b1; waddr = ptr_q[AW-1:0]; wdata = 32'(prev_q);
          state_d = SCntRd;
        end else begin
          raddr = AW'(ptr_q - CW'(1));
          state_d = SShWr;
        end
      end
      SShWr: begin
        we = 1'b1; waddr = ptr_q[AW-1:0]; wdata = rdata;
        ptr_d = ptr_q - CW'(1);
        state_d = SShRd;
      end
      // compacting merge: idx is write slot, ptr is read slot
      SMgRd: begin
        if (ptr_q == CW'(0)) begin
          raddr = '0;
          state_d = SMgChk;
        end else if (ptr_q >= cnt_q) begin
          we = 1'b1; waddr = idx_q[AW-1:0]; wdata = 32'(prev_q);
          cnt_d = idx_q + CW'(1);
          state_d = SCntRd;
        end else begin
          raddr = ptr_q[AW-1:0];
          state_d = SMgChk;
        end
      end
      SMgChk: begin
        if (ptr_q == CW'(0)) begin
          prev_d = rdata[SW:0]; ptr_d = CW'(1);
        end else begin
          if (prev_q[0] && efree) begin
            prev_d = {mg_sz, 1'b1};
          end else begin
            we = 1'b1; waddr = idx_q[AW-1:0]; wdata = 32'(prev_q);
            idx_d = idx_q + CW'(1);
            prev_d = rdata[SW:0];
          end
          ptr_d = ptr_q + CW'(1);
        end
        state_d = SMgRd;
      end
      SCntRd: begin
        idx_d = '0; sum_d = '0;
        raddr = '0;
        state_d = SCntAcc;
      end
      SCntAcc: begin
        raddr = AW'(idx_q + CW'(1));
        if (idx_q < cnt_q) begin
          if (efree) sum_d = sum_q + esz;
          idx_d = idx_q + CW'(1);
        end else begin
          free_d = 17'(sum_q);
          state_d = SDone;
        end
      end
      SDone: begin
        done_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; ready_q <= 1'b0; free_q <= '0; cnt_q <= '0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; ready_q <= ready_d; free_q <= free_d; cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; ptr_q <= ptr_d; off_q <= off_d; sum_q <= sum_d; need_q <= need_d;
    addr_q <= addr_d; isalloc_q <= isalloc_d; st_q <= st_d; pay_q <= pay_d;
    prev_q <= prev_d;
  end

  assign busy              = (state_q != SIdle);
  assign done_o            = done_q;
  assign status_o          = st_q;
  assign payload_address_o = pay_q;
  assign free_bytes_o      = ready_q ? free_q : 17'(HEAP_BYTES);

  `FFHA_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= MaxCnt, "block count overflow")
  `FFHA_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result strobe held")
  `FFHA_ASSERT(a_done_idle, clk_i, rst_ni, !done_o || !busy, "busy during result")
  `FFHA_ASSERT(a_ready_cnt, clk_i, rst_ni, !ready_q || cnt_q != '0, "ready heap with no blocks")
endmodule

### rtl/core/ffha_header_ram.sv
// Single-port-write, single-read header memory with registered read data.
// Depends on nothing; used by first_fit_heap_allocator.
module ffha_header_ram #(
  parameter int unsigned Depth = 8192,
  parameter int unsigned Width = 32,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### verif/first_fit_heap_allocator_tb.sv
// Self-checking testbench for the first-fit heap allocator: directed table, then random
// allocate/release/report/spare requests checked against an in-bench block-list model.
// Depends on ffha_pkg and first_fit_heap_allocator.
module first_fit_heap_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HeapBytes = ffha_pkg::HeapBytesDefault;
  localparam int unsigned MetaBytes = ffha_pkg::MetaBytesDefault;
  localparam int unsigned MaxBlocks = HeapBytes / 8;
  localparam int unsigned RandomRequests = 1100;
  localparam longint CycleLimit = 100_000_000;

  typedef struct packed {
    ffha_pkg::status_e status;
    logic [15:0]       payload;
    logic [16:0]       free_bytes;
  } outcome_t;

  typedef struct {
    ffha_pkg::action_e act;
    logic [15:0]       size;
    logic [15:0]       addr;
    bit                typed;
    outcome_t          want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action_i = '0;
  logic [15:0] request_size_i = '0;
  logic [15:0] release_address_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [15:0] payload_address_o;
  logic [16:0] free_bytes_o;

  first_fit_heap_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .request_size_i, .release_address_i,
    .done_o, .status_o, .payload_address_o, .free_bytes_o
  );

  always #1 clk_i = ~clk_i;

  // Block list: payload size and free flag per block, address ordered.
  int unsigned blk_size[$];
  bit          blk_free[$];
  bit          heap_ready;
  int unsigned live_addrs[$];

  outcome_t pending_results[$];
  int       errors;
  int       results_seen;
  int       n_fit, n_nofit, n_bad;
  longint   cycle_count;

  function automatic int unsigned sum_free();
    int unsigned s;
    s = 0;
    foreach (blk_size[i]) if (blk_free[i]) s += blk_size[i];
    return s;
  endfunction

  function automatic void coalesce_free();
    int i;
    i = 0;
    while (i + 1 < blk_size.size()) begin
      if (blk_free[i] && blk_free[i+1]) begin
        blk_size[i] = blk_size[i] + MetaBytes + blk_size[i+1];
        blk_size.delete(i+1);
        blk_free.delete(i+1);
      end else begin
        i++;
      end
    end
  endfunction

  function automatic outcome_t predict_heap(ffha_pkg::action_e act, logic [15:0] size,
                                            logic [15:0] addr);
    outcome_t    r;
    int unsigned need, off, sz;
    bit          hit;
    r.status = ffha_pkg::StOk;
    r.payload = '0;
    hit = 0;
    off = 0;
    if (act == ffha_pkg::ActAlloc) begin
      need = (int'(size) + 7) & ~7;
      if (!heap_ready) begin
        blk_size = '{HeapBytes - MetaBytes};
        blk_free = '{1'b1};
        heap_ready = 1;
      end
      for (int i = 0; i < blk_size.size() && !hit; i++) begin
        sz = blk_size[i];
        if (blk_free[i] && sz >= need) begin
          hit = 1;
          if (sz > need + MetaBytes + ffha_pkg::SplitSlack && blk_size.size() < MaxBlocks) begin
            blk_size.insert(i + 1, sz - need - MetaBytes);
            blk_free.insert(i + 1, 1'b1);
            blk_size[i] = need;
          end
          blk_free[i] = 0;
          r.payload = 16'(off + MetaBytes);
        end else begin
          off += MetaBytes + sz;
        end
      end
      if (!hit) r.status = ffha_pkg::StNoFit;
    end else if (act == ffha_pkg::ActRelease) begin
      for (int i = 0; i < blk_size.size() && !hit; i++) begin
        if (off + MetaBytes == addr) begin
          hit = 1;
          blk_free[i] = 1;
          coalesce_free();
        end else begin
          off += MetaBytes + blk_size[i];
        end
      end
      if (!hit) r.status = ffha_pkg::StBadAddr;
    end
    r.free_bytes = heap_ready ? 17'(sum_free()) : 17'(HeapBytes);
    return r;
  endfunction

  // Drive a request at a falling edge while the block is idle; it is taken at the next
  // rising edge, so predict it straight away.
  task automatic send_request(ffha_pkg::action_e act, logic [15:0] size, logic [15:0] addr,
                              bit typed, outcome_t want);
    outcome_t got_pred;
    int       gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    repeat (gap) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    action_i <= act;
    request_size_i <= size;
    release_address_i <= addr;
    start <= 1'b1;
    got_pred = predict_heap(act, size, addr);
    if (typed && got_pred != want)
      $display("%0t: table row disagrees with prediction: %p vs %p", $time, want, got_pred);
    pending_results.push_back(typed ? want : got_pred);
    if (act == ffha_pkg::ActAlloc && got_pred.status == ffha_pkg::StOk)
      live_addrs.push_back(got_pred.payload);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    if (rst_ni) cycle_count <= cycle_count + 1;
    if (rst_ni && done_o) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%0d free=%0d", $time,
                 status_o, payload_address_o, free_bytes_o);
        errors++;
      end else begin
        outcome_t w;
        w = pending_results.pop_front();
        case (w.status)
          ffha_pkg::StOk:    n_fit++;
          ffha_pkg::StNoFit: n_nofit++;
          default:           n_bad++;
        endcase
        if (status_o !== w.status) begin
          $display("%0t: status expected %0d got %0d", $time, w.status, status_o);
          errors++;
        end
        if (payload_address_o !== w.payload) begin
          $display("%0t: payload_address expected %0d got %0d", $time, w.payload,
                   payload_address_o);
          errors++;
        end
        if (free_bytes_o !== w.free_bytes) begin
          $display("%0t: free_bytes expected %0d got %0d", $time, w.free_bytes,
                   free_bytes_o);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Some tests failed");
    $finish;
  end

  stim_row_t table_rows[$];

  function automatic stim_row_t mk(ffha_pkg::action_e a, int s, int ad, bit t = 0,
                                   ffha_pkg::status_e st = ffha_pkg::StOk, int p = 0,
                                   int f = 0);
    stim_row_t r;
    r.act = a; r.size = 16'(s); r.addr = 16'(ad); r.typed = t;
    r.want.status = st; r.want.payload = 16'(p); r.want.free_bytes = 17'(f);
    return r;
  endfunction

  initial begin
    ffha_pkg::action_e act;
    int unsigned       idx;
    logic [15:0]       sz, ad;
    errors = 0;
    heap_ready = 0;
    cycle_count = 0;
    results_seen = 0;
    n_fit = 0; n_nofit = 0; n_bad = 0;
    // Report, spare action and release before the heap exists.
    table_rows.push_back(mk(ffha_pkg::ActReport, 0, 0, 1, ffha_pkg::StOk, 0, HeapBytes));
    table_rows.push_back(mk(ffha_pkg::ActSpare, 16'hffff, 16'hffff, 1, ffha_pkg::StOk, 0,
                            HeapBytes));
    table_rows.push_back(mk(ffha_pkg::ActRelease, 0, MetaBytes, 1, ffha_pkg::StBadAddr, 0,
                            HeapBytes));
    // Oversized first allocate initialises the heap, then fails.
    table_rows.push_back(mk(ffha_pkg::ActAlloc, 16'hffff, 0, 1, ffha_pkg::StNoFit, 0,
                            HeapBytes - MetaBytes));
    table_rows.push_back(mk(ffha_pkg::ActAlloc, 0, 0, 1, ffha_pkg::StOk, MetaBytes,
                            HeapBytes - 2 * MetaBytes));
    table_rows.push_back(mk(ffha_pkg::ActAlloc, 1, 16'haaaa));
    table_rows.push_back(mk(ffha_pkg::ActAlloc, 100, 16'h5555));
    table_rows.push_back(mk(ffha_pkg::ActRelease, 0, 0));
    table_rows.push_back(mk(ffha_pkg::ActRelease, 0, 16'hffff));
    table_rows.push_back(mk(ffha_pkg::ActRelease, 16'hffff, MetaBytes));
    table_rows.push_back(mk(ffha_pkg::ActRelease, 0, MetaBytes));
    table_rows.push_back(mk(ffha_pkg::ActAlloc, 8, 0));
    table_rows.push_back(mk(ffha_pkg::ActAlloc, 60000, 0));
    table_rows.push_back(mk(ffha_pkg::ActAlloc, 9000, 0));
    table_rows.push_back(mk(ffha_pkg::ActRelease, 0, 24 + 24 + 8));
    table_rows.push_back(mk(ffha_pkg::ActReport, 16'hffff, 16'hffff));
    table_rows.push_back(mk(ffha_pkg::ActAlloc, 65000, 0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (table_rows[i])
      send_request(table_rows[i].act, table_rows[i].size, table_rows[i].addr,
                   table_rows[i].typed, table_rows[i].want);

    for (int n = 0; n < RandomRequests; n++) begin
      idx = $urandom_range(0, 99);
      sz = $urandom_range(1, 10) == 1 ? 16'($urandom()) : 16'($urandom_range(0, 600));
      ad = 16'($urandom());
      if (idx < 50) begin
        act = ffha_pkg::ActAlloc;
      end else if (idx < 90) begin
        act = ffha_pkg::ActRelease;
        if (live_addrs.size() != 0 && idx < 85) begin
          int unsigned k;
          k = $urandom_range(0, live_addrs.size() - 1);
          ad = 16'(live_addrs[k]);
          if (idx < 80) live_addrs.delete(k);
        end
      end else begin
        act = (idx < 95) ? ffha_pkg::ActReport : ffha_pkg::ActSpare;
      end
      // Flush the heap now and then so full and empty phases both recur.
      if (n % 400 == 399) begin
        while (live_addrs.size() != 0)
          send_request(ffha_pkg::ActRelease, 16'($urandom()), 16'(live_addrs.pop_front()),
                       0, '0);
      end
      send_request(act, sz, ad, 0, '0);
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Covered %0d results: %0d ok, %0d no fit, %0d bad address",
             results_seen, n_fit, n_nofit, n_bad);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/ffha_pkg.sv
rtl/core/ffha_header_ram.sv
rtl/core/first_fit_heap_allocator.sv
verif/first_fit_heap_allocator_tb.sv
